/* hdl/llh_pkg.sv */
// shared types and constants of the line length histogram
package llh_pkg;

   // default sizes of the histogram store
   localparam int MAX_LENGTH_DEF  = 4095;
   localparam int COUNT_WIDTH_DEF = 32;

   // fixed field widths on the ports
   localparam int LEN_W      = 12;
   localparam int CNT_OUT_W  = 32;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   // text byte codes and tab spacing
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam int         TAB_STOP   = 8;

   // result queue depth
   localparam int FIFO_DEPTH = 4;

   // register indexes on the csr port
   localparam logic CSR_EXPAND_TABS  = 1'b0;
   localparam logic CSR_MATCH_LENGTH = 1'b1;

   // request kinds carried on req_tuser
   typedef enum logic [1:0] {
      OP_TEXT = 2'd0,
      OP_END  = 2'd1,
      OP_READ = 2'd2
   } opcode_type;

   // result kinds carried on rsp_tuser
   typedef enum logic {
      KIND_LINE = 1'b0,
      KIND_READ = 1'b1
   } kind_type;

   // control flags of the histogram update stage
   typedef struct packed {
      logic     valid;
      kind_type kind;
      logic     sat;
      logic     match;
      logic     in_range;
   } s1_ctrl_type;

endpackage

/* hdl/line_length_histogram.sv */
// line length histogram with tab expansion, one text byte per cycle unless stalled
//
// Takes one request per cycle while req_tready is high. Text bytes advance a column
// counter; a newline, or end of text with a partial line pending, finishes the line and
// increments its bin in a (MAX_LENGTH+1) x COUNT_WIDTH histogram memory with a registered
// read. The increment is a read-modify-write through the registered read and the update
// stage, with a forwarding register for back-to-back updates of the same bin, so a line
// can finish in every cycle. Results (line records and bin reads) leave through the update
// stage and a 4-entry queue; req_tready drops only while that queue plus the update stage
// could overflow, or during the clearing pass. After reset the memory is cleared one bin
// per cycle, all MAX_LENGTH+1 bins, with req_tready low; csr writes are taken throughout.
module line_length_histogram
   import llh_pkg::*;
#(
   parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // byte_value[7:0], bin_index[19:8], zero[23:20]
   input  logic [1:0]            req_tuser,   // opcode[1:0]
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // line_length[11:0], length_saturated[12], matches_target[13], bin_count[45:14],
   // zero[47:46]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,   // result_kind[0]
   // register writes
   input  logic                  csr_we,
   input  logic                  csr_addr,
   input  logic [LEN_W-1:0]      csr_wdata
);

   localparam int AW    = $clog2(MAX_LENGTH + 1);
   localparam int AW1   = AW + 1;
   localparam int MW    = (AW > LEN_W) ? AW : LEN_W;
   localparam int XW    = (COUNT_WIDTH > CNT_OUT_W) ? COUNT_WIDTH : CNT_OUT_W;
   localparam int NBINS = MAX_LENGTH + 1;
   localparam int PW    = $clog2(FIFO_DEPTH);
   localparam int QW    = PW + 1;
   localparam int EW    = RSP_DATA_W + 1;
   localparam logic [AW-1:0]          MAX_ADDR  = AW'(MAX_LENGTH);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // request fields
   opcode_type       req_op;
   logic [7:0]       req_byte;
   logic [LEN_W-1:0] req_idx;

   // config registers
   logic             expand_tabs_ff, expand_tabs_in;
   logic [LEN_W-1:0] match_length_ff, match_length_in;

   // line state
   logic [AW-1:0] column_ff, column_in;
   logic          clipped_ff, clipped_in;
   logic          pending_ff, pending_in;

   // clearing pass
   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // update stage
   s1_ctrl_type      s1_ff, s1_in;
   logic [AW-1:0]    s1_addr_ff, s1_addr_in;
   logic [LEN_W-1:0] s1_len_ff, s1_len_in;

   // histogram memory
   logic [COUNT_WIDTH-1:0] hist_mem [NBINS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]          mem_raddr;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [COUNT_WIDTH-1:0] mem_wdata;

   // forwarding of the last update
   logic                   fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0]          fwd_addr_ff, fwd_addr_in;
   logic [COUNT_WIDTH-1:0] fwd_data_ff, fwd_data_in;

   // result queue
   logic [EW-1:0] fifo_ff [FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QW-1:0] count_ff, count_in;

   // stage 0 helpers
   logic             req_acc;
   logic [AW1-1:0]   tab_col;
   logic [AW1-1:0]   plain_col;
   logic [AW1-1:0]   next_col;
   logic [MW-1:0]    col_ext;
   logic [MW-1:0]    mlen_ext;
   logic [MW-1:0]    idx_ext;
   logic             finish;
   logic             advance;
   logic             is_tab;

   // stage 1 helpers
   logic [COUNT_WIDTH-1:0] cur_count;
   logic [COUNT_WIDTH-1:0] inc_count;
   logic [COUNT_WIDTH-1:0] res_count;
   logic [XW-1:0]          res_count_ext;
   logic [EW-1:0]          push_entry;
   logic                   push;
   logic                   pop;
   logic [QW-1:0]          inflight;

   assign req_op   = opcode_type'(req_tuser);
   assign req_byte = req_tdata[7:0];
   assign req_idx  = req_tdata[19:8];

   // space for the request, the update stage and the queue
   assign inflight   = count_ff + QW'(s1_ff.valid);
   assign req_tready = !clr_ff && (inflight <= QW'(FIFO_DEPTH - 1));
   assign req_acc    = req_tvalid && req_tready;

   // config writes
   always_comb begin
      expand_tabs_in  = expand_tabs_ff;
      match_length_in = match_length_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_EXPAND_TABS:  expand_tabs_in  = csr_wdata[0];
            CSR_MATCH_LENGTH: match_length_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // column arithmetic
   assign tab_col   = {({1'b0, column_ff[AW-1:3]} + (AW - 2)'(1)), 3'b000};
   assign plain_col = {1'b0, column_ff} + AW1'(1);
   assign is_tab    = (req_byte == CH_TAB) && expand_tabs_ff;
   assign next_col  = is_tab ? tab_col : plain_col;
   assign col_ext   = MW'(column_ff);
   assign mlen_ext  = MW'(match_length_ff);
   assign idx_ext   = MW'(req_idx);

   // request decode
   always_comb begin
      finish  = 1'b0;
      advance = 1'b0;
      if (req_acc) begin
         case (req_op)
            OP_TEXT: begin
               finish  = (req_byte == CH_NEWLINE);
               advance = (req_byte != CH_NEWLINE);
            end
            OP_END:  finish = pending_ff;
            default: ;
         endcase
      end
   end

   // line state and update stage load
   always_comb begin
      column_in  = column_ff;
      clipped_in = clipped_ff;
      pending_in = pending_ff;
      s1_in      = '0;
      s1_addr_in = column_ff;
      s1_len_in  = col_ext[LEN_W-1:0];
      mem_raddr  = column_ff;
      if (advance) begin
         pending_in = 1'b1;
         if (next_col > AW1'(MAX_LENGTH)) begin
            column_in  = MAX_ADDR;
            clipped_in = 1'b1;
         end else begin
            column_in = next_col[AW-1:0];
         end
      end
      if (finish) begin
         s1_in.valid    = 1'b1;
         s1_in.kind     = KIND_LINE;
         s1_in.sat      = clipped_ff;
         s1_in.match    = (match_length_ff != '0) && !clipped_ff && (mlen_ext == col_ext);
         s1_in.in_range = 1'b1;
         column_in      = '0;
         clipped_in     = 1'b0;
         pending_in     = 1'b0;
      end
      if (req_acc && (req_op == OP_READ)) begin
         s1_in.valid    = 1'b1;
         s1_in.kind     = KIND_READ;
         s1_in.in_range = (idx_ext <= MW'(MAX_LENGTH));
         s1_addr_in     = idx_ext[AW-1:0];
         s1_len_in      = req_idx;
         mem_raddr      = idx_ext[AW-1:0];
      end
   end

   // bin update with forwarding of the previous write
   assign cur_count = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : rd_data_ff;
   assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_WIDTH'(1);

   always_comb begin
      res_count = '0;
      if (s1_ff.kind == KIND_LINE) begin
         res_count = inc_count;
      end else if (s1_ff.in_range) begin
         res_count = cur_count;
      end
   end

   assign res_count_ext = XW'(res_count);

   // memory write port: clearing pass or line update
   always_comb begin
      mem_we       = 1'b0;
      mem_waddr    = s1_addr_ff;
      mem_wdata    = inc_count;
      fwd_valid_in = 1'b0;
      fwd_addr_in  = s1_addr_ff;
      fwd_data_in  = inc_count;
      clr_in       = clr_ff;
      clr_addr_in  = clr_addr_ff;
      if (clr_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
         if (clr_addr_ff == MAX_ADDR) begin
            clr_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + AW'(1);
         end
      end else if (s1_ff.valid && (s1_ff.kind == KIND_LINE)) begin
         mem_we       = 1'b1;
         fwd_valid_in = 1'b1;
      end
   end

   // result queue pointers
   assign push       = s1_ff.valid;
   assign pop        = rsp_tvalid && rsp_tready;
   assign push_entry = {s1_ff.kind, 2'b00, res_count_ext[CNT_OUT_W-1:0],
                        s1_ff.match, s1_ff.sat, s1_len_ff};

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + QW'(1);
         2'b01:   count_in = count_ff - QW'(1);
         default: ;
      endcase
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tuser  = fifo_ff[rd_ptr_ff][EW-1];
   assign rsp_tdata  = fifo_ff[rd_ptr_ff][RSP_DATA_W-1:0];

   // histogram memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= hist_mem[mem_raddr];
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_addr_ff  <= s1_addr_in;
      s1_len_ff   <= s1_len_in;
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         expand_tabs_ff  <= 1'b0;
         match_length_ff <= '0;
         column_ff       <= '0;
         clipped_ff      <= 1'b0;
         pending_ff      <= 1'b0;
         clr_ff          <= 1'b1;
         clr_addr_ff     <= '0;
         s1_ff           <= '0;
         fwd_valid_ff    <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         expand_tabs_ff  <= expand_tabs_in;
         match_length_ff <= match_length_in;
         column_ff       <= column_in;
         clipped_ff      <= clipped_in;
         pending_ff      <= pending_in;
         clr_ff          <= clr_in;
         clr_addr_ff     <= clr_addr_in;
         s1_ff           <= s1_in;
         fwd_valid_ff    <= fwd_valid_in;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         count_ff        <= count_in;
      end
   end

endmodule

/* hdl/llh_checker.sv */
// port-level checks of the line length histogram, bound to the top level
module llh_checker
   import llh_pkg::*;
#(
   parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   localparam logic [LEN_W-1:0] MAX_LEN12 = LEN_W'(MAX_LENGTH);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // reset starts the clearing pass with no transfer possible
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("request taken or result shown right after reset");

   // bin read records carry no line flags
   a_read_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_READ) |-> (rsp_tdata[13:12] == 2'b00))
      else $error("bin read record with line flags");

   // a clipped line sits in the top bin and never matches
   a_clip_top: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_LINE) && rsp_tdata[12]
         |-> (rsp_tdata[11:0] == MAX_LEN12) && !rsp_tdata[13])
      else $error("clipped line not in top bin or flagged as match");

endmodule

bind line_length_histogram llh_checker #(.MAX_LENGTH(MAX_LENGTH)) u_llh_checker (.*);
